// ===== src/calendar_clock_advance_core_assert.svh =====
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_ADVANCE_CORE_ASSERT_SVH
`define CALENDAR_CLOCK_ADVANCE_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define CCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar clock check failed");

// Next-cycle implication, checked on clk and disabled during rst.
`define CCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calendar clock check failed");

`endif

// ===== src/cca_pkg.sv =====
// Types, constants and month table for the calendar clock.
package cca_pkg;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [6:0] SEC_WRAP  = 7'd60;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [6:0] YEAR_MAX  = 7'd99;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [4:0] DAYS_LEAP_FEB = 5'd29;

  // Days per month, indexed by month code; codes without meaning read 31.
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  typedef struct packed {
    logic       operation;
    logic [5:0] advance_seconds;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
    logic [4:0] load_day;
    logic [3:0] load_month;
    logic [6:0] load_year;
  } cca_req_t;

  typedef struct packed {
    logic [4:0] out_hour;
    logic [5:0] out_minute;
    logic [5:0] out_second;
    logic [4:0] out_day;
    logic [3:0] out_month;
    logic [6:0] out_year;
  } cca_rsp_t;

  // Month length; February gets 29 days when the year is a multiple of 4.
  function automatic logic [4:0] days_of(input logic [3:0] month, input logic [6:0] year);
    logic [4:0] len;
    len = MONTH_LEN[month];
    if (month == MONTH_FEB && year[1:0] == 2'b00) begin
      len = DAYS_LEAP_FEB;
    end
    return len;
  endfunction

endpackage

// ===== src/cca_stream_if.sv =====
// Valid/ready stream interface carrying one payload struct.
interface cca_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/calendar_clock_advance_core.sv =====
// Calendar clock top level: time-of-day and date keeper with load and advance.
//
//  channel | dir | payload    | transaction
//  --------+-----+------------+-------------------------------------------
//  req     | in  | cca_req_t  | load all six fields, or advance 0..59 s
//  rsp     | out | cca_rsp_t  | time and date after that request
//
// Throughput: one transaction per cycle while rsp.ready stays high; the whole carry chain
//   from seconds to year is one short combinational step.
// Path: an accepted request is held in the input register, then its response in the output register.
// Reset (rst, synchronous): pipeline empty, clock at 00:00:00, day 1, month 1,
//   year 0.
// Stalls: rsp.ready low holds the response register; req.ready falls only
//   when both the input and output registers are full and rsp is stalled.
module calendar_clock_advance_core
  import cca_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  cca_stream_if.sink    req,
  cca_stream_if.source  rsp
);

`include "calendar_clock_advance_core_assert.svh"

  // Pipeline registers
  cca_req_t in_item;
  logic     in_full;
  cca_rsp_t out_item;
  logic     out_full;

  // Clock state
  logic [5:0] cur_second;
  logic [5:0] cur_minute;
  logic [4:0] cur_hour;
  logic [4:0] cur_day;
  logic [3:0] cur_month;
  logic [6:0] cur_year;

  logic [5:0] cur_second_next;
  logic [5:0] cur_minute_next;
  logic [4:0] cur_hour_next;
  logic [4:0] cur_day_next;
  logic [3:0] cur_month_next;
  logic [6:0] cur_year_next;

  logic       pipe_adv;
  logic       step;
  logic [5:0] add_sec;
  logic [6:0] sec_sum;
  logic       sec_carry;
  logic [4:0] month_days;

  // Handshake: the output register frees the pipe when empty or taken.
  assign pipe_adv  = !out_full || rsp.ready;
  assign step      = in_full && pipe_adv;
  assign req.ready = !in_full || pipe_adv;

  assign rsp.valid   = out_full;
  assign rsp.payload = out_item;

  // Seconds: oversized advance saturates at 59; one minute carry at most.
  assign add_sec    = (in_item.advance_seconds > SEC_MAX) ? SEC_MAX : in_item.advance_seconds;
  assign sec_sum    = {1'b0, cur_second} + {1'b0, add_sec};
  assign sec_carry  = (sec_sum >= SEC_WRAP);
  assign month_days = days_of(cur_month, cur_year);

  always_comb begin
    cur_second_next = cur_second;
    cur_minute_next = cur_minute;
    cur_hour_next   = cur_hour;
    cur_day_next    = cur_day;
    cur_month_next  = cur_month;
    cur_year_next   = cur_year;
    if (in_item.operation == OP_LOAD) begin
      cur_second_next = in_item.load_second;
      cur_minute_next = in_item.load_minute;
      cur_hour_next   = in_item.load_hour;
      cur_day_next    = in_item.load_day;
      cur_month_next  = in_item.load_month;
      cur_year_next   = in_item.load_year;
    end else if (!sec_carry) begin
      cur_second_next = sec_sum[5:0];
    end else begin
      cur_second_next = 6'(sec_sum - SEC_WRAP);
      // Ripple: each field rolls over at (or past) its last valid value.
      if (cur_minute < MIN_MAX) begin
        cur_minute_next = cur_minute + 6'd1;
      end else begin
        cur_minute_next = '0;
        if (cur_hour < HOUR_MAX) begin
          cur_hour_next = cur_hour + 5'd1;
        end else begin
          cur_hour_next = '0;
          if (cur_day < month_days) begin
            cur_day_next = cur_day + 5'd1;
          end else begin
            cur_day_next = 5'd1;
            if (cur_month < MONTH_MAX) begin
              cur_month_next = cur_month + 4'd1;
            end else begin
              cur_month_next = 4'd1;
              cur_year_next  = (cur_year < YEAR_MAX) ? cur_year + 7'd1 : '0;
            end
          end
        end
      end
    end
  end

  // Control and clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full    <= 1'b0;
      out_full   <= 1'b0;
      cur_second <= '0;
      cur_minute <= '0;
      cur_hour   <= '0;
      cur_day    <= 5'd1;
      cur_month  <= 4'd1;
      cur_year   <= '0;
    end else begin
      if (req.valid && req.ready) begin
        in_full <= 1'b1;
      end else if (step) begin
        in_full <= 1'b0;
      end
      if (step) begin
        out_full   <= 1'b1;
        cur_second <= cur_second_next;
        cur_minute <= cur_minute_next;
        cur_hour   <= cur_hour_next;
        cur_day    <= cur_day_next;
        cur_month  <= cur_month_next;
        cur_year   <= cur_year_next;
      end else if (rsp.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req.payload;
    end
    if (step) begin
      out_item.out_hour   <= cur_hour_next;
      out_item.out_minute <= cur_minute_next;
      out_item.out_second <= cur_second_next;
      out_item.out_day    <= cur_day_next;
      out_item.out_month  <= cur_month_next;
      out_item.out_year   <= cur_year_next;
    end
  end

  // A pending response always mirrors the clock state.
  `CCA_ASSERT_NOW(a_rsp_matches_state, out_full, (out_item.out_hour == cur_hour) && (out_item.out_minute == cur_minute) && (out_item.out_second == cur_second) && (out_item.out_day == cur_day) && (out_item.out_month == cur_month) && (out_item.out_year == cur_year))
  // Request side stalls only with both stages full and the response stalled.
  `CCA_ASSERT_NOW(a_stall_cause, !req.ready, in_full && out_full && !rsp.ready)
  // An advance with no seconds carry leaves the minute alone.
  `CCA_ASSERT_NEXT(a_no_carry_minute, step && (in_item.operation == OP_ADVANCE) && !sec_carry, cur_minute == $past(cur_minute))
  // A load puts the requested day and year in place.
  `CCA_ASSERT_NEXT(a_load_date, step && (in_item.operation == OP_LOAD), (cur_day == $past(in_item.load_day)) && (cur_year == $past(in_item.load_year)))

endmodule
